FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge, ignored while reset is low
`define LF_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lf assertion failed");

// implication checked at every rising clock edge, reset included
`define LF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("lf assertion failed");

`endif

FILE: design/lf_pkg.sv
// shared constants, register codes and helpers of the line filter
package lf_pkg;
    localparam int LINE_MAX_DEF    = 64;
    localparam int PATTERN_MAX_DEF = 16;
    localparam int PAT_LEN_W       = 5;
    localparam int PAT_BITS        = 128;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;
    localparam logic [7:0] NEWLINE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd3;

    function automatic logic [7:0] lf_pat_byte(input logic [PAT_BITS-1:0] pat,
                                               input logic [3:0] idx);
        lf_pat_byte = pat[idx*8 +: 8];
    endfunction
endpackage

FILE: design/lf_in_if.sv
// input channel: text beats
interface lf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

FILE: design/lf_out_if.sv
// output channel: result beats
interface lf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       highlight_start;
    logic       highlight_stop;
    logic       last_of_run;
    logic       line_truncated;
    logic       any_line_matched;

    modport source (output valid, output out_byte, output highlight_start,
                    output highlight_stop, output last_of_run, output line_truncated,
                    output any_line_matched, input ready);
    modport sink   (input valid, input out_byte, input highlight_start,
                    input highlight_stop, input last_of_run, input line_truncated,
                    input any_line_matched, output ready);
endinterface

FILE: design/line_filter_substring_highlight.sv
// top level of the fixed string line filter
// usage:
// - i_in carries text beats (text_byte, end_of_text); o_out carries result beats
// - config writes through i_cfg_we / i_cfg_idx / i_cfg_data while idle:
//   0 highlight mode, 1 pattern length, 2 pattern bytes 0-7, 3 pattern bytes 8-15
// - a beat that causes no result or one pass-through result is handled in S_IDLE
// - a line release reads the line store one byte at a time: a store read (S_READ),
//   then an output register load (S_SHOW), through the single store read port
// - matching runs in a chain of window cells shifted once per accepted non end_of_text beat
// - marks of the newest stored bytes sit in a short shift register; a mark that
//   can no longer change moves into a mark store read beside the line store
// - last_of_run marks the final result caused by one input beat
// - i_in.ready drops while a release is in progress, and while the output
//   register holds a beat the receiver has not taken
// - a stalled receiver holds the output register; nothing is lost
// - reset (synchronous, active low) clears config, line state and the sticky
//   match flag; the stores need no clearing, only entries written in the
//   current line are read
module line_filter_substring_highlight import lf_pkg::*; #(
    parameter int LINE_MAX    = LINE_MAX_DEF,
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lf_in_if.sink                 i_in,
    lf_out_if.source              o_out
);
    localparam int AW  = $clog2(LINE_MAX);
    localparam int CW  = $clog2(LINE_MAX + 1);
    localparam int WN  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
    localparam int MKW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_SHOW} t_state;

    // config registers
    logic                  r_mode;
    logic [PAT_LEN_W-1:0]  r_plen;
    logic [PAT_BITS-1:0]   r_pat;

    // line state
    logic [CW-1:0]          r_fill, n_fill;
    logic [PAT_LEN_W-1:0]   r_wfill, n_wfill;
    logic                   r_has, n_has;
    logic                   r_ovf, n_ovf;
    logic                   r_ever, n_ever;
    // marks of the newest stored bytes, newest in bit 0
    logic [PATTERN_MAX-1:0] r_mk, n_mk;

    // release control and output register
    t_state                r_state;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         r_cnt;
    logic                  r_hl;
    logic                  r_clr;
    logic                  r_pmk;
    logic                  r_ov;
    logic [7:0]            r_ob;
    logic                  r_ohs, r_ohp, r_olast, r_otr, r_oany;

    logic                  w_fire, w_eot, w_nl, w_match, w_stored, w_clear;
    logic                  w_direct, w_flush, w_flush_hl, w_defer, w_ovf_put, w_show_last;
    logic [CW-1:0]         w_flush_cnt;
    logic [PAT_LEN_W-1:0]  w_len;
    logic [7:0]            w_b;
    logic [7:0]            w_q [WN];
    logic [WN-1:0]         w_eq;
    logic [7:0]            w_rdata;
    logic                  w_cur, w_prev;
    logic                  w_mk_we, w_mrd, w_mark;
    logic [CW-1:0]         w_mk_waddr, w_dist;

    assign w_b    = i_in.text_byte;
    assign w_eot  = i_in.end_of_text;
    assign w_nl   = (w_b == NEWLINE);
    assign w_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && (!r_ov || o_out.ready);

    // pattern length clamped to the usable range
    always_comb begin
        if (r_plen == '0) begin
            w_len = PAT_LEN_W'(1);
        end else if (r_plen > PAT_LEN_W'(PATTERN_MAX)) begin
            w_len = PAT_LEN_W'(PATTERN_MAX);
        end else begin
            w_len = r_plen;
        end
    end

    // window cells, newest byte in cell 0
    generate
        if (PATTERN_MAX > 1) begin : g_win
            for (genvar k = 0; k < PATTERN_MAX - 1; k++) begin : g_cell
                lf_cell #(.POS(k)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (w_fire && !w_eot),
                    .i_clear (w_clear),
                    .i_din   ((k == 0) ? w_b : w_q[(k == 0) ? 0 : k - 1]),
                    .i_pat   (r_pat),
                    .i_len   (w_len),
                    .o_q     (w_q[k]),
                    .o_eq    (w_eq[k])
                );
            end
        end else begin : g_nowin
            assign w_eq   = '1;
            assign w_q[0] = '0;
        end
    endgenerate

    assign w_match = ({1'b0, r_wfill} + 6'd1 >= {1'b0, w_len})
                  && (w_b == lf_pat_byte(r_pat, 4'(w_len - PAT_LEN_W'(1))))
                  && (&w_eq);
    assign w_stored = (r_fill < CW'(LINE_MAX));

    // line store
    lf_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_fire && !w_eot && w_stored),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (w_b),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // mark store: the oldest mark of the shift register is final once a new byte lands
    assign w_mk_we    = w_fire && !w_eot && w_stored && (int'(r_fill) >= PATTERN_MAX);
    assign w_mk_waddr = r_fill - CW'(PATTERN_MAX);

    lf_ram #(.WIDTH(1), .DEPTH(LINE_MAX)) u_marks (
        .i_clk   (i_clk),
        .i_we    (w_mk_we),
        .i_waddr (w_mk_waddr[AW-1:0]),
        .i_wdata (r_mk[PATTERN_MAX-1]),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_mrd)
    );

    assign w_show_last = (r_state == S_SHOW) && (r_idx == r_cnt - CW'(1));

    // per beat line state update
    always_comb begin
        n_fill      = r_fill;
        n_wfill     = r_wfill;
        n_has       = r_has;
        n_ovf       = r_ovf;
        n_ever      = r_ever;
        n_mk        = r_mk;
        w_direct    = 1'b0;
        w_flush     = 1'b0;
        w_flush_hl  = 1'b0;
        w_flush_cnt = r_fill;
        w_defer     = 1'b0;
        w_clear     = 1'b0;
        if (w_fire) begin
            if (w_eot) begin
                w_flush    = r_mode && r_has && (r_fill != '0);
                w_flush_hl = 1'b1;
                if (w_flush) begin
                    n_ever  = 1'b1;
                    w_defer = 1'b1;
                end else begin
                    w_clear = 1'b1;
                end
            end else begin
                if (r_wfill < PAT_LEN_W'(PATTERN_MAX - 1)) begin
                    n_wfill = r_wfill + PAT_LEN_W'(1);
                end
                if (w_stored) begin
                    n_fill = r_fill + CW'(1);
                    n_mk   = r_mk << 1;
                    if (w_match) begin
                        // mark the matched bytes, never before the line start
                        for (int k = 0; k < PATTERN_MAX; k++) begin
                            if ((PAT_LEN_W'(k) < w_len) && (CW'(k) <= r_fill)) begin
                                n_mk[k] = 1'b1;
                            end
                        end
                    end
                end else begin
                    n_ovf = 1'b1;
                end
                n_has = r_has || w_match;
                if (!r_mode) begin
                    if (r_has) begin
                        w_direct = 1'b1;
                    end else if (w_match) begin
                        w_flush     = 1'b1;
                        w_flush_cnt = n_fill;
                        n_ever      = 1'b1;
                    end
                end else if (w_nl && n_has) begin
                    w_flush     = 1'b1;
                    w_flush_hl  = 1'b1;
                    w_flush_cnt = n_fill;
                    n_ever      = 1'b1;
                end
                if (w_nl) begin
                    if (w_flush) begin
                        w_defer = 1'b1;
                    end else begin
                        w_clear = 1'b1;
                    end
                end
            end
        end
        w_ovf_put = n_ovf;
        if (w_show_last && r_clr) begin
            w_clear = 1'b1;
        end
        if (w_clear) begin
            n_fill  = '0;
            n_wfill = '0;
            n_has   = 1'b0;
            n_ovf   = 1'b0;
            n_mk    = '0;
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_plen <= PAT_LEN_W'(1);
            r_pat  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:    r_mode <= i_cfg_data[0];
                CFG_LENGTH:  r_plen <= i_cfg_data[PAT_LEN_W-1:0];
                CFG_PAT_LOW: r_pat[63:0] <= i_cfg_data;
                CFG_PAT_HI:  r_pat[127:64] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_wfill <= '0;
            r_has   <= 1'b0;
            r_ovf   <= 1'b0;
            r_ever  <= 1'b0;
            r_mk    <= '0;
        end else begin
            r_fill  <= n_fill;
            r_wfill <= n_wfill;
            r_has   <= n_has;
            r_ovf   <= n_ovf;
            r_ever  <= n_ever;
            r_mk    <= n_mk;
        end
    end

    // mark of the byte being released: newest ones from the shift register
    assign w_dist = r_cnt - CW'(1) - r_idx;

    always_comb begin
        if (int'(w_dist) < PATTERN_MAX) begin
            w_mark = r_mk[w_dist[MKW-1:0]];
        end else begin
            w_mark = w_mrd;
        end
    end

    assign w_cur  = r_hl && w_mark;
    assign w_prev = r_hl && r_pmk;

    // release sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_hl    <= 1'b0;
            r_clr   <= 1'b0;
            r_pmk   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_direct) begin
                        r_ov    <= 1'b1;
                        r_ob    <= w_b;
                        r_ohs   <= 1'b0;
                        r_ohp   <= 1'b0;
                        r_olast <= 1'b1;
                        r_otr   <= w_ovf_put;
                        r_oany  <= n_ever;
                    end else if (o_out.ready) begin
                        r_ov <= 1'b0;
                    end
                    if (w_flush) begin
                        r_state <= S_READ;
                        r_idx   <= '0;
                        r_cnt   <= w_flush_cnt;
                        r_hl    <= w_flush_hl;
                        r_clr   <= w_defer;
                        r_pmk   <= 1'b0;
                        r_otr   <= w_ovf_put;
                        r_oany  <= n_ever;
                    end
                end
                S_READ: begin
                    if (o_out.ready) begin
                        r_ov <= 1'b0;
                    end
                    // store read of r_idx lands next cycle
                    if (!r_ov || o_out.ready) begin
                        r_state <= S_SHOW;
                    end
                end
                S_SHOW: begin
                    r_ov    <= 1'b1;
                    r_ob    <= w_rdata;
                    r_ohs   <= w_cur && !w_prev;
                    r_ohp   <= !w_cur && w_prev;
                    r_olast <= w_show_last;
                    r_pmk   <= w_cur;
                    r_idx   <= r_idx + CW'(1);
                    r_state <= w_show_last ? S_IDLE : S_READ;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid            = r_ov;
    assign o_out.out_byte         = r_ob;
    assign o_out.highlight_start  = r_ohs;
    assign o_out.highlight_stop   = r_ohp;
    assign o_out.last_of_run      = r_olast;
    assign o_out.line_truncated   = r_otr;
    assign o_out.any_line_matched = r_oany;
endmodule

FILE: design/lf_ram.sv
// generic single write port ram with registered read
module lf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/lf_cell.sv
// one window cell: holds an earlier byte, shifts it on, compares it to its pattern byte
module lf_cell import lf_pkg::*; #(
    parameter int POS = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic                 i_clear,
    input  logic [7:0]           i_din,
    input  logic [PAT_BITS-1:0]  i_pat,
    input  logic [PAT_LEN_W-1:0] i_len,
    output logic [7:0]           o_q,
    output logic                 o_eq
);
    logic [7:0]           r_q;
    logic [PAT_LEN_W-1:0] w_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_q <= '0;
        end else if (i_shift) begin
            r_q <= i_din;
        end
    end

    // pattern byte that lines up with this cell
    assign w_sel = i_len - PAT_LEN_W'(2) - PAT_LEN_W'(POS);

    always_comb begin
        if (PAT_LEN_W'(POS + 1) < i_len) begin
            o_eq = (r_q == lf_pat_byte(i_pat, w_sel[3:0]));
        end else begin
            o_eq = 1'b1;
        end
    end

    assign o_q = r_q;
endmodule

FILE: design/lf_checker.sv
// port level checks of the line filter, bound to the top level
`include "assert_macros.svh"

module lf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_hl_start,
    input logic i_hl_stop,
    input logic i_any
);
    // a stalled result beat stays offered
    `LF_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    // a run cannot open and close before the same byte
    `LF_ASSERT_RST(a_hl_excl, i_clk, i_rst_n, i_out_valid |-> !(i_hl_start && i_hl_stop))
    // every emitted beat carries the sticky any_line_matched flag
    `LF_ASSERT_RST(a_any_set, i_clk, i_rst_n, i_out_valid |-> i_any)
    // reset empties the output register
    `LF_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)
endmodule

bind line_filter_substring_highlight lf_checker u_lf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hl_start  (o_out.highlight_start),
    .i_hl_stop   (o_out.highlight_stop),
    .i_any       (o_out.any_line_matched)
);

FILE: sim/tb.sv
// testbench for the fixed string line filter: directed and random text against a predictor
module tb;
    import lf_pkg::*;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       highlight_start;
        logic       highlight_stop;
        logic       last_of_run;
        logic       line_truncated;
        logic       any_line_matched;
    } line_beat_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lf_in_if  in_ch ();
    lf_out_if out_ch ();

    line_filter_substring_highlight u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // predictor copy of the configuration
    logic          mode_hl;
    logic [4:0]    pat_len_reg;
    logic [127:0]  pat_bits;

    // predictor copy of the line state
    logic [7:0]    line_mem [LINE_MAX_DEF];
    logic          mark_mem [LINE_MAX_DEF];
    logic [7:0]    window_mem [PATTERN_MAX_DEF];
    int            win_fill;
    int            line_len;
    logic          line_hit;
    logic          line_over;
    logic          seen_hit;

    text_beat_t    text_q [$];
    line_beat_t    line_expect_q [$];

    int  fail_count;
    int  beats_sent;
    int  beats_seen;
    int  lines_hit;
    int  idle_cycles;
    bit  feeding;
    bit  in_taken;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    function automatic logic [7:0] pat_at(input int i);
        return pat_bits[i*8 +: 8];
    endfunction

    function automatic int used_len();
        int n;
        n = pat_len_reg;
        if (n == 0) n = 1;
        if (n > PATTERN_MAX_DEF) n = PATTERN_MAX_DEF;
        return n;
    endfunction

    function automatic void wipe_line();
        for (int i = 0; i < LINE_MAX_DEF; i++) mark_mem[i] = 1'b0;
        for (int i = 0; i < PATTERN_MAX_DEF; i++) window_mem[i] = 8'h00;
        win_fill  = 0;
        line_len  = 0;
        line_hit  = 1'b0;
        line_over = 1'b0;
    endfunction

    function automatic void push_line_beat(input logic [7:0] b, input logic hs,
                                           input logic hp);
        line_beat_t r;
        r.out_byte         = b;
        r.highlight_start  = hs;
        r.highlight_stop   = hp;
        r.last_of_run      = 1'b0;
        r.line_truncated   = line_over;
        r.any_line_matched = seen_hit;
        line_expect_q.push_back(r);
    endfunction

    // releases the stored line with run open/close flags from the marks
    function automatic void release_marked();
        logic cur, prv;
        for (int i = 0; i < line_len; i++) begin
            cur = mark_mem[i];
            prv = (i > 0) ? mark_mem[i-1] : 1'b0;
            push_line_beat(line_mem[i], cur && !prv, !cur && prv);
        end
    endfunction

    // works out the beats one text beat causes, flags the last of them
    function automatic void predict_text(input text_beat_t t);
        int  len, pos, start_size;
        logic hit;
        len        = used_len();
        start_size = line_expect_q.size();
        hit        = 1'b0;
        if (t.end_of_text) begin
            if (mode_hl && line_hit && line_len > 0) begin
                seen_hit = 1'b1;
                release_marked();
            end
            wipe_line();
        end else begin
            // newest window byte at index 0 lines up with pattern byte len-2
            if (win_fill + 1 >= len && t.text_byte == pat_at(len - 1)) begin
                hit = 1'b1;
                for (int k = 0; k + 1 < len; k++)
                    if (window_mem[k] != pat_at(len - 2 - k)) hit = 1'b0;
            end
            for (int k = PATTERN_MAX_DEF - 1; k > 0; k--) window_mem[k] = window_mem[k-1];
            window_mem[0] = t.text_byte;
            if (win_fill < PATTERN_MAX_DEF - 1) win_fill++;

            pos = line_len;
            if (pos < LINE_MAX_DEF) begin
                line_mem[pos] = t.text_byte;
                mark_mem[pos] = 1'b0;
                line_len = pos + 1;
                if (hit)
                    for (int k = 0; k < len && k <= pos; k++) mark_mem[pos-k] = 1'b1;
            end else begin
                line_over = 1'b1;
            end

            if (!mode_hl) begin
                if (line_hit) begin
                    push_line_beat(t.text_byte, 1'b0, 1'b0);
                end else if (hit) begin
                    line_hit = 1'b1;
                    seen_hit = 1'b1;
                    for (int k = 0; k < line_len; k++)
                        push_line_beat(line_mem[k], 1'b0, 1'b0);
                end
            end else begin
                if (hit) line_hit = 1'b1;
                if (t.text_byte == NEWLINE && line_hit) begin
                    seen_hit = 1'b1;
                    release_marked();
                end
            end
            if (hit) line_hit = 1'b1;
            if (t.text_byte == NEWLINE) wipe_line();
        end
        if (line_expect_q.size() > start_size) begin
            line_expect_q[$].last_of_run = 1'b1;
            lines_hit++;
        end
    endfunction

    // random gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // driver: present beats from the queue at the falling edge
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap    <= 0;
        end else if (in_ch.valid && !in_taken) begin
            // hold the beat until it is taken
        end else if (send_gap > 0) begin
            in_ch.valid <= 1'b0;
            send_gap    <= send_gap - 1;
        end else if (feeding && text_q.size() > 0) begin
            in_ch.valid       <= 1'b1;
            in_ch.text_byte   <= text_q[0].text_byte;
            in_ch.end_of_text <= text_q[0].end_of_text;
            send_gap          <= pick_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver back-pressure, with gaps of random length
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            out_ch.ready <= 1'b1;
            stall_left   <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        end
    end

    // monitor: predict on accepted text beats, check accepted line beats
    always @(posedge i_clk) begin
        line_beat_t got, want;
        bit moved;
        if (i_rst_n) begin
            moved    = 1'b0;
            in_taken <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready) begin
                text_beat_t t;
                t.text_byte   = in_ch.text_byte;
                t.end_of_text = in_ch.end_of_text;
                void'(text_q.pop_front());
                predict_text(t);
                beats_sent++;
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                got.out_byte         = out_ch.out_byte;
                got.highlight_start  = out_ch.highlight_start;
                got.highlight_stop   = out_ch.highlight_stop;
                got.last_of_run      = out_ch.last_of_run;
                got.line_truncated   = out_ch.line_truncated;
                got.any_line_matched = out_ch.any_line_matched;
                beats_seen++;
                moved = 1'b1;
                if (line_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat byte %02h", got.out_byte));
                end else begin
                    want = line_expect_q.pop_front();
                    if (got.out_byte != want.out_byte)
                        report_mismatch($sformatf("out_byte %02h want %02h",
                                                  got.out_byte, want.out_byte));
                    if (got.highlight_start != want.highlight_start)
                        report_mismatch("highlight_start");
                    if (got.highlight_stop != want.highlight_stop)
                        report_mismatch("highlight_stop");
                    if (got.last_of_run != want.last_of_run)
                        report_mismatch("last_of_run");
                    if (got.line_truncated != want.line_truncated)
                        report_mismatch("line_truncated");
                    if (got.any_line_matched != want.any_line_matched)
                        report_mismatch("any_line_matched");
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d beats still expected",
                         line_expect_q.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // one configuration write, applied to the predictor at the same edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:    mode_hl = val[0];
            CFG_LENGTH:  pat_len_reg = val[4:0];
            CFG_PAT_LOW: pat_bits[63:0] = val;
            CFG_PAT_HI:  pat_bits[127:64] = val;
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_pattern(input logic hl, input int len, input logic [127:0] p);
        write_reg(CFG_MODE, {63'd0, hl});
        write_reg(CFG_LENGTH, 64'(len));
        write_reg(CFG_PAT_LOW, p[63:0]);
        write_reg(CFG_PAT_HI, p[127:64]);
    endtask

    // send the queued beats and wait until every result has come out
    task automatic run_phase();
        feeding = 1'b1;
        wait (text_q.size() == 0);
        feeding = 1'b0;
        wait (line_expect_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void add_text(input logic [7:0] b);
        text_q.push_back('{text_byte: b, end_of_text: 1'b0});
    endfunction

    function automatic void add_eot();
        text_q.push_back('{text_byte: 8'($urandom), end_of_text: 1'b1});
    endfunction

    // random letter drawn mostly from a small alphabet so matches happen
    function automatic logic [7:0] pick_char(input logic [127:0] p, input int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return p[$urandom_range(0, len - 1)*8 +: 8];
        if (r < 55) return NEWLINE;
        if (r < 85) return 8'h61 + 8'($urandom_range(0, 3));
        return 8'($urandom);
    endfunction

    // random lines: most carry the pattern somewhere, some lines are long
    task automatic random_text(input int beats, input logic [127:0] p, input int len);
        int n, ln, at;
        n = 0;
        while (n < beats) begin
            ln = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 20);
            at = ($urandom_range(0, 2) != 0) ? $urandom_range(0, ln) : -1;
            for (int i = 0; i < ln; i++) begin
                if (i == at)
                    for (int k = 0; k < len; k++) add_text(p[k*8 +: 8]);
                add_text(pick_char(p, len));
            end
            if ($urandom_range(0, 4) == 0) add_eot();
            else add_text(NEWLINE);
            n += ln + 1;
            if (at >= 0 && at < ln) n += len;
        end
    endtask

    function automatic logic [127:0] rand_pattern();
        logic [127:0] p;
        for (int i = 0; i < 16; i++) p[i*8 +: 8] = 8'h61 + 8'($urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0) p[$urandom_range(0, 15)*8 +: 8] = 8'($urandom);
        return p;
    endfunction

    initial begin
        logic [127:0] pat;
        int len;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_MODE;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.text_byte   = 8'h00;
        in_ch.end_of_text = 1'b0;
        out_ch.ready      = 1'b0;
        fail_count  = 0;
        beats_sent  = 0;
        beats_seen  = 0;
        lines_hit   = 0;
        idle_cycles = 0;
        feeding     = 1'b0;
        in_taken    = 1'b0;
        mode_hl     = 1'b0;
        pat_len_reg = 5'd1;
        pat_bits    = '0;
        seen_hit    = 1'b0;
        wipe_line();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset pattern is a single zero byte, extremes of the text byte
        add_text(8'hFF); add_text(8'h00); add_text(8'h7F); add_text(NEWLINE);
        add_text(8'h80); add_eot();
        run_phase();

        // directed: two-byte pattern in highlight mode, overlapping runs, eot release
        set_pattern(1'b1, 2, 128'h6161);
        add_text(8'h62); add_text(8'h61); add_text(8'h61); add_text(8'h61);
        add_text(8'h62); add_text(8'h61); add_text(8'h61); add_text(NEWLINE);
        add_text(8'h61); add_text(8'h61); add_eot();
        add_eot();
        run_phase();

        // directed: length zero acts as one, length above the maximum acts as full
        set_pattern(1'b0, 0, 128'h41);
        add_text(8'h42); add_text(8'h41); add_text(8'h43); add_text(NEWLINE);
        run_phase();
        pat = rand_pattern();
        set_pattern(1'b1, 31, pat);
        for (int k = 0; k < 16; k++) add_text(pat[k*8 +: 8]);
        add_text(NEWLINE);
        run_phase();

        // directed: overlong line, plain mode, match completing past the store
        set_pattern(1'b0, 1, 128'h5A);
        for (int i = 0; i < 66; i++) add_text(8'h2E);
        add_text(8'h5A); add_text(8'h2E); add_text(NEWLINE);
        run_phase();

        // random phases across modes and pattern lengths, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            pat = rand_pattern();
            len = (ph == 0) ? 1 : (ph == 1) ? 16 : $urandom_range(1, 16);
            set_pattern(1'(ph % 2), len, pat);
            random_text(30, pat, len);
            run_phase();
        end

        $display("sent %0d text beats, checked %0d line beats in %0d releases",
                 beats_sent, beats_seen, lines_hit);
        $display("covered plain and highlight modes, pattern lengths 1 to 16, long lines");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
